[design/mfd_pkg.sv]
// Shared types, codes and constants of the Dinic max-flow block.
`default_nettype none
package mfd_pkg;

    // Default sizes
    localparam int MAX_NODES_DEF = 32;
    localparam int MAX_EDGES_DEF = 256;
    localparam int CAP_BITS_DEF  = 16;

    // Fixed port widths
    localparam int IN_NODE_W = 5;
    localparam int IN_NODES  = 1 << IN_NODE_W;
    localparam int IN_CAP_W  = 16;
    localparam int FLOW_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // Starting bottleneck of an augmenting path when capacities have 30 bits or more
    localparam logic [31:0] BN_INIT = 32'h3f3f_3f3f;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_BFS_INIT,
        ST_BFS_DEQ,
        ST_BFS_RD,
        ST_BFS_EV,
        ST_PHASE_CHK,
        ST_FP_INIT,
        ST_FP_RD,
        ST_FP_EV,
        ST_FP_FAIL,
        ST_FP_POP,
        ST_AUG_MRD,
        ST_AUG_MEV,
        ST_UPD_RD,
        ST_UPD_EV,
        ST_DONE
    } t_state;

    // Compare results of the arc unit
    typedef struct packed {
        logic tail_match;
        logic has_res;
        logic below_bn;
    } t_arc_flags;

endpackage
`default_nettype wire

[design/mfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [ADDR_W-1:0]    i_waddr,
    input  wire [WIDTH-1:0]     i_wdata,
    input  wire [ADDR_W-1:0]    i_raddr,
    output logic [WIDTH-1:0]    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/mfd_arc_unit.sv]
// Shared arc unit: picks one arc of a stored pair, compares it, updates residuals.
`default_nettype none
module mfd_arc_unit #(
    parameter int NB = 5,
    parameter int CW = 16
) (
    input  wire [2*NB+2*CW-1:0]  i_row,
    input  wire                  i_odd,
    input  wire [NB-1:0]         i_node,
    input  wire [CW-1:0]         i_bn,
    output logic [NB-1:0]        o_tail,
    output logic [NB-1:0]        o_head,
    output logic [CW-1:0]        o_res,
    output mfd_pkg::t_arc_flags  o_flags,
    output logic [2*NB+2*CW-1:0] o_row_upd
);
    logic [NB-1:0] w_from;
    logic [NB-1:0] w_to;
    logic [CW-1:0] w_fwd;
    logic [CW-1:0] w_rev;
    logic [CW-1:0] w_dec;
    logic [CW-1:0] w_inc;

    assign {w_from, w_to, w_fwd, w_rev} = i_row;

    // Select forward or reverse arc of the pair
    always_comb begin
        o_tail = i_odd ? w_to   : w_from;
        o_head = i_odd ? w_from : w_to;
        o_res  = i_odd ? w_rev  : w_fwd;
    end

    // Compares against the current node and bottleneck
    always_comb begin
        o_flags.tail_match = (o_tail == i_node);
        o_flags.has_res    = (o_res != '0);
        o_flags.below_bn   = (o_res < i_bn);
    end

    // Push bottleneck along the arc, return it on the partner
    always_comb begin
        w_dec = o_res - i_bn;
        w_inc = (i_odd ? w_fwd : w_rev) + i_bn;
        if (i_odd) begin
            o_row_upd = {w_from, w_to, w_inc, w_dec};
        end else begin
            o_row_upd = {w_from, w_to, w_dec, w_inc};
        end
    end
endmodule
`default_nettype wire

[design/max_flow_dinic.sv]
// Top level of the Dinic max-flow block: edge loading, level build, path search and augment.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | from_node, to_node, capacity, last_edge
//  out     | output    | o_out_valid / i_out_ready | max_flow, edge_overflow
//  cfg     | input     | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// Edges load while the block is idle; a last edge starts the flow run. Each BFS phase
// scans every arc once per reached node, each search step reads and tests one arc,
// each augment reads every path arc and then writes it back, all through the one arc RAM port.
// Reset is synchronous, active low; the arc store needs no clearing.
// A finished result waits in the output register while the next edges load.
`default_nettype none
module max_flow_dinic #(
    parameter int MAX_NODES = mfd_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = mfd_pkg::MAX_EDGES_DEF,
    parameter int CAP_BITS  = mfd_pkg::CAP_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire [mfd_pkg::IN_NODE_W-1:0]    i_from_node,
    input  wire [mfd_pkg::IN_NODE_W-1:0]    i_to_node,
    input  wire [mfd_pkg::IN_CAP_W-1:0]     i_capacity,
    input  wire                             i_last_edge,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [mfd_pkg::FLOW_W-1:0]      o_max_flow,
    output logic                            o_edge_overflow,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [mfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [mfd_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    localparam int NB  = $clog2(MAX_NODES);
    localparam int QW  = $clog2(MAX_NODES + 1);
    localparam int RAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SAW = RAW + 1;
    localparam int AW  = SAW + 1;
    localparam int RCW = $clog2(MAX_EDGES + 1);
    localparam int CW  = CAP_BITS;
    localparam int RW  = 2 * NB + 2 * CW;
    localparam int FW  = mfd_pkg::FLOW_W;
    localparam logic [CW-1:0] BnInit =
        (CAP_BITS >= 30) ? CW'(mfd_pkg::BN_INIT) : {CW{1'b1}};

    // Node index reduction table
    logic [NB-1:0] w_mod [mfd_pkg::IN_NODES];
    for (genvar g = 0; g < mfd_pkg::IN_NODES; g++) begin : g_mod
        assign w_mod[g] = NB'(g % MAX_NODES);
    end

    mfd_pkg::t_state r_state, n_state;

    logic [mfd_pkg::CFG_DAT_W-1:0] r_src_cfg, r_snk_cfg;
    logic [NB-1:0]  r_s, n_s, r_t, n_t;
    logic [RCW-1:0] r_rows, n_rows;
    logic           r_ovf, n_ovf;
    logic [AW-1:0]  r_a, n_a;
    logic [NB-1:0]  r_v, n_v, r_vlev, n_vlev;
    logic [QW-1:0]  r_rd, n_rd, r_wr, n_wr;
    logic [NB-1:0]  r_depth, n_depth, r_i, n_i;
    logic [CW-1:0]  r_bn, n_bn;
    logic [FW-1:0]  r_flow, n_flow;
    logic [SAW-1:0] r_pa, n_pa;
    logic           r_out_valid, n_out_valid;
    logic [FW-1:0]  r_out_flow, n_out_flow;
    logic           r_out_ovf, n_out_ovf;

    logic [NB-1:0]        r_level [MAX_NODES];
    logic [MAX_NODES-1:0] r_reach;
    logic [MAX_NODES-1:0] r_dead;
    logic [NB-1:0]        r_qn [MAX_NODES];
    logic [NB-1:0]        r_ql [MAX_NODES];
    logic [SAW-1:0]       r_stk [MAX_NODES];

    // Control strobes
    logic           w_accept;
    logic           w_bfs_clear;
    logic           w_enq;
    logic           w_push;
    logic           w_kill;
    logic [NB-1:0]  w_stk_idx;
    logic [SAW-1:0] w_stk_rd;
    logic [AW-1:0]  w_a_end;
    logic           w_odd;

    logic           w_we;
    logic [RAW-1:0] w_waddr;
    logic [RW-1:0]  w_wdata;
    logic [RAW-1:0] w_raddr;
    logic [RW-1:0]  w_rdata;

    logic [NB-1:0]       w_tail, w_head;
    logic [CW-1:0]       w_res;
    mfd_pkg::t_arc_flags w_flags;
    logic [RW-1:0]       w_row_upd;

    mfd_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_EDGES)
    ) u_arcs (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mfd_arc_unit #(
        .NB (NB),
        .CW (CW)
    ) u_arc_unit (
        .i_row     (w_rdata),
        .i_odd     (w_odd),
        .i_node    (r_v),
        .i_bn      (r_bn),
        .o_tail    (w_tail),
        .o_head    (w_head),
        .o_res     (w_res),
        .o_flags   (w_flags),
        .o_row_upd (w_row_upd)
    );

    assign o_in_ready      = (r_state == mfd_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_max_flow      = r_out_flow;
    assign o_edge_overflow = r_out_ovf;

    assign w_accept  = i_in_valid & o_in_ready;
    assign w_stk_idx = (r_state == mfd_pkg::ST_FP_FAIL) ? (r_depth - 1'b1) : r_i;
    assign w_stk_rd  = r_stk[w_stk_idx];
    assign w_a_end   = AW'({r_rows, 1'b0});

    // Pick which arc of the pair the unit looks at
    always_comb begin
        case (r_state)
            mfd_pkg::ST_FP_POP:  w_odd = r_pa[0];
            mfd_pkg::ST_AUG_MEV,
            mfd_pkg::ST_UPD_EV:  w_odd = w_stk_rd[0];
            default:             w_odd = r_a[0];
        endcase
    end

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_s         = r_s;
        n_t         = r_t;
        n_rows      = r_rows;
        n_ovf       = r_ovf;
        n_a         = r_a;
        n_v         = r_v;
        n_vlev      = r_vlev;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_depth     = r_depth;
        n_i         = r_i;
        n_bn        = r_bn;
        n_flow      = r_flow;
        n_pa        = r_pa;
        n_out_valid = r_out_valid;
        n_out_flow  = r_out_flow;
        n_out_ovf   = r_out_ovf;
        w_bfs_clear = 1'b0;
        w_enq       = 1'b0;
        w_push      = 1'b0;
        w_kill      = 1'b0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_raddr     = r_a[RAW:1];

        // Drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mfd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (r_rows < RCW'(MAX_EDGES)) begin
                        w_we    = 1'b1;
                        w_waddr = r_rows[RAW-1:0];
                        w_wdata = {w_mod[i_from_node], w_mod[i_to_node],
                                   CW'(i_capacity), {CW{1'b0}}};
                        n_rows  = r_rows + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_edge) begin
                        n_state = mfd_pkg::ST_START;
                    end
                end
            end
            mfd_pkg::ST_START: begin
                n_s = w_mod[r_src_cfg];
                n_t = w_mod[r_snk_cfg];
                if (w_mod[r_src_cfg] == w_mod[r_snk_cfg]) begin
                    n_state = mfd_pkg::ST_DONE;
                end else begin
                    n_state = mfd_pkg::ST_BFS_INIT;
                end
            end
            mfd_pkg::ST_BFS_INIT: begin
                w_bfs_clear = 1'b1;
                n_rd        = '0;
                n_wr        = QW'(1);
                n_state     = mfd_pkg::ST_BFS_DEQ;
            end
            mfd_pkg::ST_BFS_DEQ: begin
                if (r_rd == r_wr) begin
                    n_state = mfd_pkg::ST_PHASE_CHK;
                end else begin
                    n_v     = r_qn[r_rd[NB-1:0]];
                    n_vlev  = r_ql[r_rd[NB-1:0]];
                    n_rd    = r_rd + 1'b1;
                    n_a     = '0;
                    n_state = mfd_pkg::ST_BFS_RD;
                end
            end
            mfd_pkg::ST_BFS_RD: begin
                if (r_a == w_a_end) begin
                    n_state = mfd_pkg::ST_BFS_DEQ;
                end else begin
                    n_state = mfd_pkg::ST_BFS_EV;
                end
            end
            mfd_pkg::ST_BFS_EV: begin
                if (w_flags.tail_match && w_flags.has_res && !r_reach[w_head]) begin
                    w_enq = 1'b1;
                    n_wr  = r_wr + 1'b1;
                end
                n_a     = r_a + 1'b1;
                n_state = mfd_pkg::ST_BFS_RD;
            end
            mfd_pkg::ST_PHASE_CHK: begin
                if (r_reach[r_t]) begin
                    n_state = mfd_pkg::ST_FP_INIT;
                end else begin
                    n_state = mfd_pkg::ST_DONE;
                end
            end
            mfd_pkg::ST_FP_INIT: begin
                n_v     = r_s;
                n_depth = '0;
                n_a     = '0;
                n_state = mfd_pkg::ST_FP_RD;
            end
            mfd_pkg::ST_FP_RD: begin
                if (r_v == r_t) begin
                    n_i     = '0;
                    n_bn    = BnInit;
                    n_state = mfd_pkg::ST_AUG_MRD;
                end else if (r_a == w_a_end) begin
                    n_state = mfd_pkg::ST_FP_FAIL;
                end else begin
                    n_state = mfd_pkg::ST_FP_EV;
                end
            end
            mfd_pkg::ST_FP_EV: begin
                // Advance along an arc that climbs to a higher level and a live node
                if (w_flags.tail_match && w_flags.has_res && r_reach[w_head] &&
                    (r_level[w_head] > r_level[r_v]) && !r_dead[w_head]) begin
                    w_push  = 1'b1;
                    n_depth = r_depth + 1'b1;
                    n_v     = w_head;
                    n_a     = '0;
                end else begin
                    n_a = r_a + 1'b1;
                end
                n_state = mfd_pkg::ST_FP_RD;
            end
            mfd_pkg::ST_FP_FAIL: begin
                w_kill = 1'b1;
                if (r_depth == '0) begin
                    n_state = mfd_pkg::ST_BFS_INIT;
                end else begin
                    // Retreat to the tail of the last arc and resume after it
                    n_depth = r_depth - 1'b1;
                    n_pa    = w_stk_rd;
                    n_a     = AW'(w_stk_rd) + 1'b1;
                    w_raddr = w_stk_rd[SAW-1:1];
                    n_state = mfd_pkg::ST_FP_POP;
                end
            end
            mfd_pkg::ST_FP_POP: begin
                n_v     = w_tail;
                n_state = mfd_pkg::ST_FP_RD;
            end
            mfd_pkg::ST_AUG_MRD: begin
                w_raddr = w_stk_rd[SAW-1:1];
                if (r_i == r_depth) begin
                    n_i     = '0;
                    n_state = mfd_pkg::ST_UPD_RD;
                end else begin
                    n_state = mfd_pkg::ST_AUG_MEV;
                end
            end
            mfd_pkg::ST_AUG_MEV: begin
                if (w_flags.below_bn) begin
                    n_bn = w_res;
                end
                n_i     = r_i + 1'b1;
                n_state = mfd_pkg::ST_AUG_MRD;
            end
            mfd_pkg::ST_UPD_RD: begin
                w_raddr = w_stk_rd[SAW-1:1];
                if (r_i == r_depth) begin
                    n_flow  = r_flow + FW'(r_bn);
                    n_state = mfd_pkg::ST_FP_INIT;
                end else begin
                    n_state = mfd_pkg::ST_UPD_EV;
                end
            end
            mfd_pkg::ST_UPD_EV: begin
                w_we    = 1'b1;
                w_waddr = w_stk_rd[SAW-1:1];
                w_wdata = w_row_upd;
                n_i     = r_i + 1'b1;
                n_state = mfd_pkg::ST_UPD_RD;
            end
            mfd_pkg::ST_DONE: begin
                // Hand the result over and clear the graph
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_flow  = r_flow;
                    n_out_ovf   = r_ovf;
                    n_rows      = '0;
                    n_ovf       = 1'b0;
                    n_flow      = '0;
                    n_state     = mfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mfd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfd_pkg::ST_IDLE;
            r_src_cfg   <= mfd_pkg::CFG_DAT_W'(0);
            r_snk_cfg   <= mfd_pkg::CFG_DAT_W'(1);
            r_rows      <= '0;
            r_ovf       <= 1'b0;
            r_flow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_ovf       <= n_ovf;
            r_flow      <= n_flow;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mfd_pkg::CFG_SOURCE: r_src_cfg <= i_cfg_data;
                    mfd_pkg::CFG_SINK:   r_snk_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_s        <= n_s;
        r_t        <= n_t;
        r_a        <= n_a;
        r_v        <= n_v;
        r_vlev     <= n_vlev;
        r_rd       <= n_rd;
        r_wr       <= n_wr;
        r_depth    <= n_depth;
        r_i        <= n_i;
        r_bn       <= n_bn;
        r_pa       <= n_pa;
        r_out_flow <= n_out_flow;
        r_out_ovf  <= n_out_ovf;
    end

    // Level, reach, dead marks, BFS queue and path stack
    always_ff @(posedge i_clk) begin
        if (w_bfs_clear) begin
            r_reach      <= {{(MAX_NODES-1){1'b0}}, 1'b1} << r_s;
            r_dead       <= '0;
            r_level[r_s] <= '0;
            r_qn[0]      <= r_s;
            r_ql[0]      <= '0;
        end
        if (w_enq) begin
            r_reach[w_head]       <= 1'b1;
            r_level[w_head]       <= r_vlev + 1'b1;
            r_qn[r_wr[NB-1:0]]    <= w_head;
            r_ql[r_wr[NB-1:0]]    <= r_vlev + 1'b1;
        end
        if (w_kill) begin
            r_dead[r_v] <= 1'b1;
        end
        if (w_push) begin
            r_stk[r_depth] <= r_a[SAW-1:0];
        end
    end
endmodule
`default_nettype wire

[design/mfd_checker.sv]
// Port-level checker of the Dinic max-flow block, bound to the top level.
`default_nettype none
module mfd_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire o_in_ready,
    input wire i_last_edge,
    input wire o_out_valid,
    input wire i_out_ready,
    input wire [mfd_pkg::FLOW_W-1:0] o_max_flow
);
    // Hold a pending result until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_max_flow))
        else $error("result dropped or changed while stalled");

    // Stop taking edges once the last edge starts the run
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_edge |=> !o_in_ready)
        else $error("edge accepted during flow run");

    // A new result only comes out of a run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a flow run");

    // Come out of reset with no result
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind max_flow_dinic mfd_checker u_mfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_last_edge (i_last_edge),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_max_flow  (o_max_flow)
);
`default_nettype wire
